// ===== hw/rtl/ppr_pkg.sv =====
package ppr_pkg;

    localparam int ErrW   = 32;
    localparam int GainW  = 16;
    localparam int IntegW = 13;
    localparam int SumW   = 35;

    localparam logic signed [IntegW-1:0] IMAX_RAW  = 13'sd4095;
    localparam logic        [GainW-1:0]  MIN_PULSE = 16'd1024;

    typedef enum logic [1:0] {
        CFG_GAIN_P    = 2'd0,
        CFG_GAIN_I    = 2'd1,
        CFG_GAIN_D    = 2'd2,
        CFG_OUT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ErrW-1:0] p;
        logic signed [ErrW-1:0] i;
        logic signed [ErrW-1:0] d;
    } t_prod;

    typedef struct packed {
        logic [GainW-1:0] mag;
        logic             neg;
    } t_res;

    // floor(gain * e / 65536): arithmetic shift of the exact product
    function automatic logic signed [ErrW-1:0] frac_mul(
        input logic        [GainW-1:0] gain,
        input logic signed [ErrW-1:0]  e
    );
        logic signed [ErrW+GainW:0] prod;
        prod = $signed({1'b0, gain}) * e;
        return prod[ErrW+GainW-1:GainW];
    endfunction

endpackage

// ===== hw/rtl/ppr_combine.sv =====
module ppr_combine
    import ppr_pkg::*;
(
    input  t_prod                     i_prod,
    input  logic signed [IntegW-1:0]  i_integ,
    input  logic signed [ErrW-1:0]    i_prev_d,
    input  logic        [GainW-1:0]   i_limit,
    output logic signed [IntegW-1:0]  o_integ,
    output t_res                      o_res
);

    logic signed [ErrW:0]   integ_raw;
    logic signed [ErrW:0]   d_diff;
    logic signed [SumW-1:0] sum;
    logic        [SumW-1:0] mag;

    always_comb begin
        integ_raw = {{(ErrW+1-IntegW){i_integ[IntegW-1]}}, i_integ}
                  + {i_prod.i[ErrW-1], i_prod.i};
        // saturate to the integral window
        if (integ_raw > $signed({{(ErrW+1-IntegW){1'b0}}, IMAX_RAW})) begin
            o_integ = IMAX_RAW;
        end else if (integ_raw < -$signed({{(ErrW+1-IntegW){1'b0}}, IMAX_RAW})) begin
            o_integ = -IMAX_RAW;
        end else begin
            o_integ = integ_raw[IntegW-1:0];
        end

        d_diff = {i_prod.d[ErrW-1], i_prod.d} - {i_prev_d[ErrW-1], i_prev_d};

        sum = {{(SumW-ErrW){i_prod.p[ErrW-1]}}, i_prod.p}
            + {{(SumW-IntegW){o_integ[IntegW-1]}}, o_integ}
            + {{(SumW-ErrW-1){d_diff[ErrW]}}, d_diff};

        o_res.neg = sum[SumW-1];
        mag       = o_res.neg ? (~sum + 1'b1) : sum;

        // cap first, then drop anything shorter than the minimum pulse
        if (mag > {{(SumW-GainW){1'b0}}, i_limit}) begin
            o_res.mag = i_limit;
        end else if (mag < {{(SumW-GainW){1'b0}}, MIN_PULSE}) begin
            o_res.mag = '0;
        end else begin
            o_res.mag = mag[GainW-1:0];
        end
    end

endmodule

// ===== hw/rtl/pid_pulse_regulator_top.sv =====
// A result passes the input, product and result registers in that order after its error
// sample is accepted, and is then held valid on the master side until it is taken.
// Throughput: one sample per cycle while the master side does not stall; the three gain
// multipliers share the product stage and the integral update sits in the result stage.
// Reset (synchronous, active low): pipeline empty, gains zero, limit 65535,
// integral and previous derivative product zero.
module pid_pulse_regulator_top
    import ppr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [GainW-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [ErrW-1:0]  i_s_axis_tdata,    // [31:0] error_in
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [GainW-1:0] o_m_axis_tdata,    // [15:0] drive_mag
    output logic             o_m_axis_tuser     // [0] drive_neg
);

    logic [GainW-1:0] r_gain_p, r_gain_i, r_gain_d, r_limit;

    logic                     r_v1, n_v1;
    logic signed [ErrW-1:0]   r_err;
    logic                     r_v2, n_v2;
    t_prod                    r_prod, n_prod;
    logic                     r_vo, n_vo;
    t_res                     r_res;
    logic signed [IntegW-1:0] r_integ;
    logic signed [ErrW-1:0]   r_prev_d;

    logic                     s_acc, adv_2, adv_o, rdy_1, rdy_2;
    t_res                     n_res;
    logic signed [IntegW-1:0] n_integ;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_limit  <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:    r_gain_p <= i_cfg_wdata;
                CFG_GAIN_I:    r_gain_i <= i_cfg_wdata;
                CFG_GAIN_D:    r_gain_d <= i_cfg_wdata;
                CFG_OUT_LIMIT: r_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage handshake: a stage advances when the next one is empty or moving on
    always_comb begin
        adv_o = r_v2 && (!r_vo || i_m_axis_tready);
        rdy_2 = !r_v2 || adv_o;
        adv_2 = r_v1 && rdy_2;
        rdy_1 = !r_v1 || adv_2;
        s_acc = i_s_axis_tvalid && rdy_1;

        n_v1 = s_acc ? 1'b1 : (adv_2 ? 1'b0 : r_v1);
        n_v2 = adv_2 ? 1'b1 : (adv_o ? 1'b0 : r_v2);
        n_vo = adv_o ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_vo);

        n_prod.p = frac_mul(r_gain_p, r_err);
        n_prod.i = frac_mul(r_gain_i, r_err);
        n_prod.d = frac_mul(r_gain_d, r_err);
    end

    ppr_combine u_combine (
        .i_prod   (r_prod),
        .i_integ  (r_integ),
        .i_prev_d (r_prev_d),
        .i_limit  (r_limit),
        .o_integ  (n_integ),
        .o_res    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_vo     <= 1'b0;
            r_integ  <= '0;
            r_prev_d <= '0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_vo <= n_vo;
            // state moves only when a sample reaches the result register
            if (adv_o) begin
                r_integ  <= n_integ;
                r_prev_d <= r_prod.d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_err <= i_s_axis_tdata;
        end
        if (adv_2) begin
            r_prod <= n_prod;
        end
        if (adv_o) begin
            r_res <= n_res;
        end
    end

    assign o_s_axis_tready = rdy_1;
    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = r_res.mag;
    assign o_m_axis_tuser  = r_res.neg;

    a_integ_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= IMAX_RAW) && (r_integ >= -IMAX_RAW))
        else $error("integral outside clamp window");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv_o |=> $stable(r_integ) && $stable(r_prev_d))
        else $error("controller state changed without a transaction");

    a_prev_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_o |=> r_prev_d == $past(r_prod.d))
        else $error("previous derivative product not captured");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_m_axis_tready) |-> !adv_o)
        else $error("result overwritten while stalled");

endmodule
